>>> rtl/vte_pkg.sv
// Package for the value table engine: widths, mode codes, register indexes.
// Used by the interfaces, the top level and the testbench.
package vte_pkg;
  localparam int Depth = 64;
  localparam int AddrW = $clog2(Depth);
  localparam int FillW = $clog2(Depth + 1);

  typedef enum logic [2:0] {
    MODE_APPEND  = 3'd0,
    MODE_DEL_ALL = 3'd1,
    MODE_DEL_ONE = 3'd2,
    MODE_COUNT   = 3'd3,
    MODE_READ    = 3'd4,
    MODE_SORT    = 3'd5
  } mode_e;

  localparam logic REG_SORT_EN  = 1'b0;
  localparam logic REG_SORT_ASC = 1'b1;

  typedef struct packed {
    logic [2:0]        mode;
    logic signed [31:0] value;
    logic [5:0]        index;
  } req_t;

  typedef struct packed {
    logic signed [31:0] data;
    logic              ok;
    logic [6:0]        fill;
  } rsp_t;
endpackage

>>> rtl/vte_if.sv
// Valid/ready channel carrying one payload struct.
// Depends on vte_pkg.
interface vte_req_if;
  logic          valid;
  logic          ready;
  vte_pkg::req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface vte_rsp_if;
  logic          valid;
  logic          ready;
  vte_pkg::rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/vte_ram.sv
// Single-port-write, one-read synchronous RAM, registered read data.
// No package dependency.
module vte_ram #(
  parameter int Words = 64,
  parameter int Width = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Words)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Words)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Words];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

>>> rtl/value_table_engine_top.sv
// Top level of the value table engine: sequencer around one entry RAM.
// Depends on vte_pkg, vte_if.sv and vte_ram.
//
//  channel  | dir | payload
//  ---------+-----+------------------------------
//  req      | in  | mode, value, index
//  rsp      | out | data, ok, fill
//  cfg      | in  | cfg_we_i, cfg_idx_i, cfg_data_i
//
// Append writes the RAM on acceptance, read waits in S_RD_WAIT; count and delete
// scan the entries in turn through the RAM read port (S_SCAN_RD, then S_SCAN_CK
// for each entry; delete-all rechecks each slot it refills). Sort is insertion sort.
// Reset clears fill and sets config to sort off, ascending; entries are undefined until written.
// One item at a time; the response register parts the two sides, so a new
// request is taken while a response waits, and its result holds in S_DONE
// until the response register is free.
module value_table_engine_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  vte_req_if.sink                   req,
  vte_rsp_if.source                 rsp,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [0:0]                cfg_data_i
);
  import vte_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_CK, S_DEL_RD, S_DEL_WR,
    S_RD_WAIT, S_SRT_KEY, S_SRT_PRV, S_SRT_CK, S_SRT_PUT, S_DONE
  } state_e;

  state_e            state_q;
  logic              sort_en_q, sort_asc_q;
  logic [FillW-1:0]  fill_q;
  req_t              req_q;
  logic [FillW-1:0]  i_q, j_q;
  logic [31:0]       key_q, cnt_q;
  logic              ok_q;
  rsp_t              rsp_q;
  logic              rsp_valid_q;

  logic              we;
  logic [AddrW-1:0]  waddr, raddr;
  logic [31:0]       wdata, rdata;

  vte_ram #(.Words(Depth), .Width(32)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  // Key order test: signed compare in requested direction.
  logic key_first;
  assign key_first = sort_asc_q ? ($signed(key_q) < $signed(rdata))
                                : ($signed(key_q) > $signed(rdata));

  logic [FillW-1:0] last;
  assign last = fill_q - 1'b1;

  // RAM port drive per state.
  always_comb begin
    we = 1'b0; waddr = '0; wdata = key_q; raddr = i_q[AddrW-1:0];
    case (state_q)
      S_IDLE: begin
        raddr = req.payload.index;
        if (req.valid && req.ready && req.payload.mode == MODE_APPEND
            && fill_q != FillW'(Depth)) begin
          we = 1'b1; waddr = fill_q[AddrW-1:0]; wdata = req.payload.value;
        end
      end
      S_SCAN_RD: raddr = i_q[AddrW-1:0];
      S_DEL_RD:  raddr = last[AddrW-1:0];
      S_DEL_WR: begin
        we = 1'b1; waddr = i_q[AddrW-1:0]; wdata = rdata;
      end
      S_SRT_KEY: raddr = i_q[AddrW-1:0];
      S_SRT_PRV: raddr = AddrW'(j_q - 1'b1);
      S_SRT_CK: begin
        if (j_q != '0 && key_first) begin
          we = 1'b1; waddr = j_q[AddrW-1:0]; wdata = rdata;
        end
      end
      S_SRT_PUT: begin
        we = 1'b1; waddr = j_q[AddrW-1:0]; wdata = key_q;
      end
      default: ;
    endcase
  end

  assign req.ready = (state_q == S_IDLE);
  assign rsp.valid = rsp_valid_q;
  assign rsp.payload = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sort_en_q <= 1'b0;
      sort_asc_q <= 1'b1;
      fill_q <= '0;
      rsp_valid_q <= 1'b0;
      i_q <= '0; j_q <= '0; cnt_q <= '0; ok_q <= 1'b0;
      key_q <= '0; req_q <= '0; rsp_q <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_SORT_EN) sort_en_q <= cfg_data_i[0];
        else sort_asc_q <= cfg_data_i[0];
      end
      // S_DONE reloads the response register itself
      if (rsp_valid_q && rsp.ready && state_q != S_DONE) rsp_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (req.valid && req.ready) begin
            req_q <= req.payload;
            i_q <= (req.payload.mode == MODE_SORT) ? FillW'(1) : '0;
            cnt_q <= '0;
            ok_q <= (req.payload.mode == MODE_APPEND) && (fill_q != FillW'(Depth));
            case (req.payload.mode)
              MODE_APPEND: begin
                if (fill_q != FillW'(Depth)) begin
                  fill_q <= fill_q + 1'b1;
                end
                state_q <= S_DONE;
              end
              MODE_DEL_ALL, MODE_DEL_ONE, MODE_COUNT: state_q <= S_SCAN_RD;
              MODE_READ: state_q <= S_RD_WAIT;
              MODE_SORT: begin
                state_q <= sort_en_q ? S_SRT_KEY : S_DONE;
              end
              default: state_q <= S_DONE;
            endcase
          end
        end
        S_SCAN_RD: state_q <= (i_q < fill_q) ? S_SCAN_CK : S_DONE;
        S_SCAN_CK: begin
          if (rdata == req_q.value) begin
            cnt_q <= cnt_q + 1'b1;
            if (req_q.mode == MODE_COUNT) begin
              i_q <= i_q + 1'b1; state_q <= S_SCAN_RD;
            end else begin
              ok_q <= 1'b1; state_q <= S_DEL_RD;
            end
          end else begin
            i_q <= i_q + 1'b1; state_q <= S_SCAN_RD;
          end
        end
        S_DEL_RD: begin
          fill_q <= last;
          state_q <= S_DEL_WR;
        end
        S_DEL_WR: begin
          // write the moved entry, then recheck slot (delete-all) or finish
          state_q <= (req_q.mode == MODE_DEL_ALL) ? S_SCAN_RD : S_DONE;
        end
        S_RD_WAIT: begin
          if ({1'b0, req_q.index} < fill_q) begin
            cnt_q <= rdata; ok_q <= 1'b1;
          end
          state_q <= S_DONE;
        end
        S_SRT_KEY: begin
          j_q <= i_q;
          state_q <= (i_q < fill_q) ? S_SRT_PRV : S_DONE;
        end
        S_SRT_PRV: begin
          if (state_q == S_SRT_PRV && j_q == i_q) key_q <= rdata;
          state_q <= (j_q == '0) ? S_SRT_PUT : S_SRT_CK;
        end
        S_SRT_CK: begin
          if (j_q != '0 && key_first) begin
            j_q <= j_q - 1'b1;
            state_q <= (j_q == FillW'(1)) ? S_SRT_PUT : S_SRT_PRV;
          end else state_q <= S_SRT_PUT;
        end
        S_SRT_PUT: begin
          i_q <= i_q + 1'b1;
          state_q <= S_SRT_KEY;
        end
        S_DONE: begin
          // hold the result until the response register is free
          if (!rsp_valid_q || rsp.ready) begin
            rsp_q.data <= (req_q.mode == MODE_DEL_ONE) ? '0 : cnt_q;
            rsp_q.ok <= ok_q;
            rsp_q.fill <= 7'(fill_q);
            rsp_valid_q <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // The key read issued in S_SRT_KEY lands during S_SRT_PRV with j == i,
  // so key capture is valid there; later S_SRT_PRV visits have j < i.

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !req.ready) else $error("ready while busy");
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(Depth)) else $error("fill overflow");
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && !rsp.ready) |=> (rsp_valid_q && $stable(rsp_q)))
    else $error("response dropped");
  a_append_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we && state_q == S_IDLE) |=> (fill_q == $past(fill_q) + 1'b1))
    else $error("append did not grow fill");
endmodule

>>> tb/value_table_engine_top_tb.sv
// Self-checking testbench for value_table_engine_top: random and directed table operations.
// Depends on vte_pkg, vte_if.sv and the value_table_engine_top RTL.
module value_table_engine_top_tb;
  import vte_pkg::*;

  // Mirror of the table: contents, fill and sort settings, plus the queue of
  // expected responses. Contents and fill are updated once per accepted request.
  class table_scoreboard;
    logic [31:0] slots[Depth];
    int unsigned fill;
    bit          sort_en;
    bit          sort_asc;
    rsp_t        pending[$];
    int          errors;

    function void clear();
      fill     = 0;
      sort_en  = 0;
      sort_asc = 1;
      pending.delete();
    endfunction

    // Insertion sort on the signed value of the used slots.
    function void organize();
      logic [31:0] key;
      int j;
      for (int i = 1; i < fill; i++) begin
        key = slots[i];
        j = i;
        while (j > 0 && (sort_asc ? ($signed(key) < $signed(slots[j-1]))
                                  : ($signed(key) > $signed(slots[j-1])))) begin
          slots[j] = slots[j-1];
          j--;
        end
        slots[j] = key;
      end
    endfunction

    function void note_request(req_t r);
      rsp_t e;
      int i;
      e.data = '0;
      e.ok   = 1'b0;
      case (r.mode)
        MODE_APPEND: if (fill < Depth) begin
          slots[fill] = r.value;
          fill++;
          e.ok = 1'b1;
        end
        MODE_DEL_ALL: begin
          i = 0;
          while (i < fill) begin
            if (slots[i] == r.value) begin
              fill--;
              slots[i] = slots[fill];
              e.data++;
            end else begin
              i++;
            end
          end
          e.ok = (e.data != 0);
        end
        MODE_DEL_ONE: begin
          for (i = 0; i < fill; i++) begin
            if (slots[i] == r.value) begin
              fill--;
              slots[i] = slots[fill];
              e.ok = 1'b1;
              break;
            end
          end
        end
        MODE_COUNT: for (i = 0; i < fill; i++) if (slots[i] == r.value) e.data++;
        MODE_READ: if (r.index < fill) begin
          e.data = slots[r.index];
          e.ok   = 1'b1;
        end
        MODE_SORT: if (sort_en) organize();
        default: ;
      endcase
      e.fill = fill[6:0];
      pending.push_back(e);
    endfunction

    task report_mismatch(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_response(rsp_t got);
      rsp_t e;
      if (pending.size() == 0) begin
        report_mismatch("response with nothing expected");
        return;
      end
      e = pending.pop_front();
      if (got.data !== e.data)
        report_mismatch($sformatf("data %0d, expected %0d", got.data, e.data));
      if (got.ok !== e.ok)
        report_mismatch($sformatf("ok %0b, expected %0b", got.ok, e.ok));
      if (got.fill !== e.fill)
        report_mismatch($sformatf("fill %0d, expected %0d", got.fill, e.fill));
    endtask
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic       cfg_idx_i;
  logic [0:0] cfg_data_i;

  vte_req_if req_if ();
  vte_rsp_if rsp_if ();

  value_table_engine_top u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req       (req_if.sink),
    .rsp       (rsp_if.source),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  table_scoreboard sb = new();
  bit quiet;         // when set, neither side idles
  bit stim_done;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Response side: stall at random, check each transfer at the rising edge.
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      rsp_if.ready <= quiet || ($urandom_range(99) >= 10);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) sb.check_response(rsp_if.payload);
  end

  // Drive one request and hold it until the transfer; note it in the mirror.
  // Valid stays high into the next request unless an idle cycle or drain
  // drops it.
  task automatic send_request(input logic [2:0] mode, input logic [31:0] value,
                              input logic [5:0] index);
    req_t r;
    while (!quiet && $urandom_range(99) < 10) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    r.mode  = mode;
    r.value = value;
    r.index = index;
    req_if.valid   <= 1'b1;
    req_if.payload <= r;
    do @(posedge clk_i); while (!req_if.ready);
    sb.note_request(r);
    @(negedge clk_i);
  endtask

  // Drop valid, wait until every expected response has come, then settle.
  task automatic drain();
    req_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_SORT_EN) sb.sort_en = data;
    else sb.sort_asc = data;
    @(negedge clk_i);
  endtask

  // Values from a small pool make matches common; the rest span the field.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(3))
      0: return $urandom;
      1: return {$urandom_range(1) ? 32'h8000_0000 : 32'h7fff_fff0} + $urandom_range(15);
      default: return $signed($urandom_range(8)) - 4;
    endcase
  endfunction

  // Random mix: appends are the most common request.
  task automatic random_phase(input int n);
    int unsigned m;
    for (int k = 0; k < n; k++) begin
      m = $urandom_range(99);
      if (m < 40)      send_request(MODE_APPEND, pick_value(), '0);
      else if (m < 52) send_request(MODE_DEL_ALL, pick_value(), 6'($urandom));
      else if (m < 64) send_request(MODE_DEL_ONE, pick_value(), 6'($urandom));
      else if (m < 76) send_request(MODE_COUNT, pick_value(), 6'($urandom));
      else if (m < 90) send_request(MODE_READ, $urandom, 6'($urandom_range(Depth - 1)));
      else if (m < 97) send_request(MODE_SORT, $urandom, 6'($urandom));
      else             send_request(3'($urandom_range(6, 7)), $urandom, 6'($urandom));
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = 1'b0;
    cfg_data_i     = 1'b0;
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    quiet          = 1'b0;
    stim_done      = 1'b0;
    sb.clear();
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: empty-table cases, extremes, index 0, sort off then on.
    send_request(MODE_READ, '0, 6'd0);
    send_request(MODE_DEL_ONE, 32'd5, '0);
    send_request(MODE_SORT, '0, '0);
    send_request(MODE_APPEND, 32'h8000_0000, '0);
    send_request(MODE_APPEND, 32'h7fff_ffff, '0);
    send_request(MODE_APPEND, 32'hffff_ffff, '0);
    send_request(MODE_APPEND, 32'h7fff_ffff, '0);
    send_request(MODE_READ, '0, 6'd0);
    send_request(MODE_READ, '0, 6'd63);
    send_request(MODE_COUNT, 32'h7fff_ffff, '0);
    send_request(MODE_SORT, '0, '0);       // disabled: no change
    send_request(3'd6, 32'hffff_ffff, 6'h3f);
    send_request(3'd7, 32'h0, 6'h0);
    drain();
    write_reg(REG_SORT_EN, 1'b1);
    send_request(MODE_SORT, '0, '0);
    send_request(MODE_READ, '0, 6'd0);
    send_request(MODE_DEL_ALL, 32'h7fff_ffff, '0);
    send_request(MODE_DEL_ONE, 32'h8000_0000, '0);
    drain();
    write_reg(REG_SORT_ASC, 1'b0);
    for (int k = 0; k < Depth + 1; k++)        // fill to the brim, two rejected
      send_request(MODE_APPEND, k[0] ? 32'h0000_0003 : 32'hffff_fffd, '0);
    send_request(MODE_SORT, '0, '0);
    send_request(MODE_READ, '0, 6'd63);
    send_request(MODE_DEL_ALL, 32'h0000_0003, '0);  // refilled slots rechecked

    // Random phases across all register settings; one with no idling.
    for (int p = 0; p < 6; p++) begin
      drain();                                  // every expected result back
      write_reg(REG_SORT_EN, p[0]);
      write_reg(REG_SORT_ASC, p[1]);
      quiet = (p == 3);
      random_phase(135);
    end
    quiet = 1'b0;
    drain();
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    if (sb.errors == 0) $display("[value_table_engine_top] OK");
    else $display("[value_table_engine_top] ERROR");
    $finish;
  end

  initial begin
    #1_000_000_000;
    $display("[value_table_engine_top] ERROR");
    $finish;
  end
endmodule
